// File: rtl/core/asa_pkg.sv
// ----------------------------------------------------------------------------
// asa_pkg
// Shared types and constants for the adaptive slot admission controller.
// ----------------------------------------------------------------------------
package asa_pkg;

    // Pool size and limit widths
    localparam int unsigned MAX_SLOTS   = 256;
    localparam int unsigned SLOT_W      = 9;
    localparam int unsigned TIME_W      = 32;

    // Limit policy constants
    localparam logic [SLOT_W-1:0] STATIC_RESET = 9'd32;
    localparam logic [SLOT_W-1:0] STATIC_MIN   = 9'd8;
    localparam logic [SLOT_W-1:0] STATIC_MAX   = SLOT_W'(MAX_SLOTS);
    localparam logic [SLOT_W-1:0] UNLIMITED    = 9'd511;
    localparam logic [SLOT_W-1:0] DROP_FLOOR   = 9'd16;
    localparam logic [SLOT_W-1:0] DROP_MARGIN  = 9'd4;
    localparam logic [SLOT_W-1:0] RAISE_STEP   = 9'd2;

    // Register widths and reset values
    localparam int unsigned BUDGET_W = 20;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned IVL_W    = 16;
    localparam int unsigned PROD_W   = BUDGET_W + PCT_W;

    localparam logic [PCT_W-1:0] PCT_MIN   = 7'd10;
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd50;
    localparam logic [IVL_W-1:0] QUIET_RESET = 16'd10000;
    localparam logic [IVL_W-1:0] RAISE_RESET = 16'd3000;
    localparam logic [IVL_W-1:0] DROP_RESET  = 16'd2000;

    // budget*pct/100/128 == (budget*pct >> 9) / 25.
    // Quotient by 25 via reciprocal: (y * 5243) >> 17, exact for y < 43690.
    localparam int unsigned PRE_SHIFT  = 9;
    localparam int unsigned QIN_W      = 13;
    localparam int unsigned DIV_SHIFT  = 17;
    localparam logic [QIN_W-1:0] DIV_MULT  = 13'd5243;
    // Quotient reaches MAX_SLOTS at this y
    localparam logic [QIN_W-1:0] SAT_LEVEL = QIN_W'(MAX_SLOTS * 25);

    // Event kinds
    typedef enum logic [1:0] {
        KIND_ACQUIRE = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_FAILURE = 2'd2,
        KIND_QUERY   = 2'd3
    } kind_t;

    // Register indexes
    localparam int unsigned ADDR_W = 5;
    typedef enum logic [2:0] {
        REG_BUDGET  = 3'd0,
        REG_PERCENT = 3'd1,
        REG_QUIET   = 3'd2,
        REG_RAISE   = 3'd3,
        REG_DROP    = 3'd4
    } reg_idx_t;

endpackage

// File: rtl/core/adaptive_slot_admission.sv
// ----------------------------------------------------------------------------
// adaptive_slot_admission
// Admission controller for a pool of decoder slots with a static budget
// limit and a dynamic limit that backs off after failures.
//
//   channel  | dir | beat contents
//   ---------+-----+----------------------------------------------------
//   s_*      | in  | tuser[1:0] kind, tdata[31:0] now_ms
//   m_*      | out | tdata[0] granted, [9:1] in_use, [18:10] effective_limit
//   apb      | cfg | 5 registers at byte address 4*i, 32-bit data
//
// One beat per cycle sustained while m_tready holds high; a beat enters
// the input register, the whole event is resolved in the cycle it moves
// to the result register, which drives the result beat.
// A held result stalls the input register, which in turn drops s_tready.
// With a nonzero budget, a budget or percent write recomputes the static limit from a registered product.
// Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
module adaptive_slot_admission (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] now_ms
    input  logic [1:0]                    s_tuser,   // [1:0] kind
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [0] granted, [9:1] in_use,
                                                     // [18:10] effective_limit
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [asa_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import asa_pkg::*;

    // Configuration registers
    logic [BUDGET_W-1:0] budget_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic [IVL_W-1:0]    quiet_reg;
    logic [IVL_W-1:0]    raise_ivl_reg;
    logic [IVL_W-1:0]    drop_ivl_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                recalc_reg;

    // Event state
    logic [SLOT_W-1:0]   held_reg,    held_next;
    logic [SLOT_W-1:0]   static_reg,  static_next;
    logic [SLOT_W-1:0]   dyn_reg,     dyn_next;
    logic [TIME_W-1:0]   fail_t_reg,  fail_t_next;
    logic [TIME_W-1:0]   raise_t_reg, raise_t_next;
    logic [TIME_W-1:0]   drop_t_reg,  drop_t_next;

    // Pipeline registers
    logic                in_valid_reg;
    kind_t               in_kind_reg;
    logic [TIME_W-1:0]   in_now_reg;
    logic                out_valid_reg;
    logic                out_grant_reg, out_grant_next;
    logic [SLOT_W-1:0]   out_use_reg;
    logic [SLOT_W-1:0]   out_lim_reg,  out_lim_next;

    logic                advance;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;
    logic [PCT_W-1:0]    pct_sat;
    logic [BUDGET_W-1:0] budget_new;
    logic [PCT_W-1:0]    pct_new;
    logic [QIN_W-1:0]    q_in;
    logic [2*QIN_W-1:0]  q_prod;
    logic [SLOT_W-1:0]   q_val;
    logic                q_big;

    // Handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_lim_reg, out_use_reg, out_grant_reg};
    assign pready   = 1'b1;

    // Register decode
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        if (pwdata[6:0] < PCT_MIN)
            pct_sat = PCT_MIN;
        else if (pwdata[6:0] > PCT_MAX)
            pct_sat = PCT_MAX;
        else
            pct_sat = pwdata[6:0];
        budget_new = (cfg_idx == REG_BUDGET)  ? pwdata[BUDGET_W-1:0] : budget_reg;
        pct_new    = (cfg_idx == REG_PERCENT) ? pct_sat : pct_reg;
    end

    // Read mux
    always_comb
    begin
        case (cfg_idx)
            REG_BUDGET:  prdata = {12'd0, budget_reg};
            REG_PERCENT: prdata = {25'd0, pct_reg};
            REG_QUIET:   prdata = {16'd0, quiet_reg};
            REG_RAISE:   prdata = {16'd0, raise_ivl_reg};
            REG_DROP:    prdata = {16'd0, drop_ivl_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Configuration write, product registered for the limit recompute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg    <= '0;
            pct_reg       <= PCT_RESET;
            quiet_reg     <= QUIET_RESET;
            raise_ivl_reg <= RAISE_RESET;
            drop_ivl_reg  <= DROP_RESET;
            recalc_reg    <= 1'b0;
        end
        else
        begin
            recalc_reg <= 1'b0;
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_BUDGET:  budget_reg    <= budget_new;
                    REG_PERCENT: pct_reg       <= pct_new;
                    REG_QUIET:   quiet_reg     <= pwdata[IVL_W-1:0];
                    REG_RAISE:   raise_ivl_reg <= pwdata[IVL_W-1:0];
                    REG_DROP:    drop_ivl_reg  <= pwdata[IVL_W-1:0];
                    default:     ;
                endcase
                recalc_reg <= ((cfg_idx == REG_BUDGET) || (cfg_idx == REG_PERCENT))
                              && (budget_new != '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(budget_new) * PROD_W'(pct_new);
    end

    // Static limit: product / 12800 clamped to STATIC_MIN..MAX_SLOTS
    always_comb
    begin
        q_in   = prod_reg[PRE_SHIFT+QIN_W-1:PRE_SHIFT];
        q_big  = (|prod_reg[PROD_W-1:PRE_SHIFT+QIN_W]) || (q_in >= SAT_LEVEL);
        q_prod = (2*QIN_W)'(q_in) * (2*QIN_W)'(DIV_MULT);
        q_val  = q_prod[DIV_SHIFT+SLOT_W-1:DIV_SHIFT];
        if (!recalc_reg)
            static_next = static_reg;
        else if (q_big)
            static_next = STATIC_MAX;
        else if (q_val < STATIC_MIN)
            static_next = STATIC_MIN;
        else
            static_next = q_val;
    end

    // Event resolution
    always_comb
    begin
        logic [SLOT_W-1:0] dyn_t;
        logic [SLOT_W-1:0] eff_t;
        logic [SLOT_W-1:0] target;
        logic              quiet_ok;
        logic              raise_ok;
        logic              drop_ok;

        held_next      = held_reg;
        dyn_next       = dyn_reg;
        fail_t_next    = fail_t_reg;
        raise_t_next   = raise_t_reg;
        drop_t_next    = drop_t_reg;
        out_grant_next = 1'b0;

        quiet_ok = (in_now_reg - fail_t_reg)  >= TIME_W'(quiet_reg);
        raise_ok = (in_now_reg - raise_t_reg) >= TIME_W'(raise_ivl_reg);
        drop_ok  = (in_now_reg - drop_t_reg)  >= TIME_W'(drop_ivl_reg);
        target   = (held_reg > DROP_MARGIN) ? (held_reg - DROP_MARGIN) : '0;
        if (target < DROP_FLOOR)
            target = DROP_FLOOR;

        // raise attempt ahead of the acquire
        dyn_t = dyn_reg;
        if ((in_kind_reg == KIND_ACQUIRE) && (dyn_reg < static_reg) && quiet_ok && raise_ok)
            dyn_t = dyn_reg + RAISE_STEP;
        eff_t = (static_reg < dyn_t) ? static_reg : dyn_t;

        case (in_kind_reg)
            KIND_ACQUIRE:
            begin
                if (dyn_t != dyn_reg)
                    raise_t_next = in_now_reg;
                dyn_next = dyn_t;
                if (held_reg < eff_t)
                begin
                    held_next      = held_reg + 9'd1;
                    out_grant_next = 1'b1;
                end
            end
            KIND_RELEASE:
            begin
                if (held_reg != '0)
                    held_next = held_reg - 9'd1;
            end
            KIND_FAILURE:
            begin
                fail_t_next = in_now_reg;
                if (drop_ok)
                begin
                    drop_t_next = in_now_reg;
                    if (target < dyn_reg)
                        dyn_next = target;
                end
            end
            default: ;
        endcase

        out_lim_next = (static_reg < dyn_next) ? static_reg : dyn_next;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            static_reg    <= STATIC_RESET;
            dyn_reg       <= UNLIMITED;
            fail_t_reg    <= '0;
            raise_t_reg   <= '0;
            drop_t_reg    <= '0;
        end
        else
        begin
            static_reg <= static_next;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (advance && in_valid_reg)
            begin
                held_reg    <= held_next;
                dyn_reg     <= dyn_next;
                fail_t_reg  <= fail_t_next;
                raise_t_reg <= raise_t_next;
                drop_t_reg  <= drop_t_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg <= kind_t'(s_tuser);
            in_now_reg  <= s_tdata;
        end
        if (advance && in_valid_reg)
        begin
            out_grant_reg <= out_grant_next;
            out_use_reg   <= held_next;
            out_lim_reg   <= out_lim_next;
        end
    end

endmodule

// File: verif/tb_adaptive_slot_admission.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_slot_admission
// Self-checking testbench for the slot admission controller. A directed
// script covers reset behavior, the time thresholds and register corner
// cases. Random phases with different budgets and intervals follow, while
// both stream sides idle and stall at varying rates. Every result beat is
// compared with a typed verdict or a behavioral model of limits and slots.
// ----------------------------------------------------------------------------
module tb_adaptive_slot_admission;

    import asa_pkg::*;

    localparam int unsigned NUM_REGS     = 5;
    localparam int unsigned REG_STRIDE   = 4;
    localparam int unsigned PCT_SCALE    = 100;
    localparam int unsigned MB_PER_SLOT  = 128;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned MODE_SPAN    = 30;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned SCRIPT_LEN   = 25;
    localparam int unsigned NUM_PHASES   = 5;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] in_use;
        logic [SLOT_W-1:0] limit;
    } verdict_t;

    typedef enum logic {ROW_EVENT, ROW_WRITE} row_op_t;

    typedef struct {
        row_op_t     op;
        kind_t       kind;
        logic [31:0] now;
        int unsigned reg_idx;
        logic [31:0] wval;
        bit          known;
        verdict_t    verdict;
    } script_row_t;

    typedef struct {
        logic [31:0] budget;
        logic [31:0] pct;
        logic [31:0] quiet;
        logic [31:0] raise;
        logic [31:0] drop;
        int          n_events;
        int          w_acq;
        int          w_rel;
        int          w_fail;
        int          step_max;
    } phase_plan_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = '0;   // [31:0] now_ms
    logic [1:0]          s_tuser = '0;   // [1:0] kind
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [23:0]         m_tdata;        // [0] granted, [9:1] in_use,
                                         // [18:10] effective_limit
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Model registers and state
    logic [BUDGET_W-1:0] cfg_budget;
    logic [PCT_W-1:0]    cfg_pct;
    logic [IVL_W-1:0]    cfg_quiet;
    logic [IVL_W-1:0]    cfg_raise_ivl;
    logic [IVL_W-1:0]    cfg_drop_ivl;
    logic [SLOT_W-1:0]   held;
    logic [SLOT_W-1:0]   lim_static;
    logic [SLOT_W-1:0]   lim_dyn;
    logic [TIME_W-1:0]   t_fail;
    logic [TIME_W-1:0]   t_raise;
    logic [TIME_W-1:0]   t_drop;

    verdict_t            expected_verdicts[$];
    int unsigned         mismatches = 0;
    int unsigned         events_sent = 0;
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_stall_pct = 0;
    logic [31:0]         clock_ms = '0;

    adaptive_slot_admission i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Directed script: reset behavior, thresholds, time wrap, register corners
    script_row_t script [SCRIPT_LEN] = '{
        '{ROW_EVENT, KIND_QUERY,   32'd0,          0, '0, 1'b1, '{1'b0, 9'd0, 9'd32}},
        '{ROW_EVENT, KIND_RELEASE, 32'd0,          0, '0, 1'b1, '{1'b0, 9'd0, 9'd32}},
        '{ROW_EVENT, KIND_ACQUIRE, 32'd0,          0, '0, 1'b1, '{1'b1, 9'd1, 9'd32}},
        '{ROW_EVENT, KIND_FAILURE, 32'd0,          0, '0, 1'b1, '{1'b0, 9'd1, 9'd32}},
        '{ROW_EVENT, KIND_FAILURE, 32'd1999,       0, '0, 1'b1, '{1'b0, 9'd1, 9'd32}},
        '{ROW_EVENT, KIND_FAILURE, 32'd2000,       0, '0, 1'b1, '{1'b0, 9'd1, 9'd16}},
        '{ROW_EVENT, KIND_ACQUIRE, 32'd11999,      0, '0, 1'b0, '0},
        '{ROW_EVENT, KIND_ACQUIRE, 32'd12000,      0, '0, 1'b0, '0},
        '{ROW_EVENT, KIND_ACQUIRE, 32'd14999,      0, '0, 1'b0, '0},
        '{ROW_EVENT, KIND_ACQUIRE, 32'hAAAA_AAAA,  0, '0, 1'b0, '0},
        '{ROW_EVENT, KIND_FAILURE, 32'h5555_5555,  0, '0, 1'b0, '0},
        '{ROW_EVENT, KIND_ACQUIRE, 32'hFFFF_FFFF,  0, '0, 1'b0, '0},
        '{ROW_EVENT, KIND_FAILURE, 32'hFFFF_FFFF,  0, '0, 1'b0, '0},
        '{ROW_EVENT, KIND_FAILURE, 32'h0000_0005,  0, '0, 1'b0, '0},
        '{ROW_EVENT, KIND_RELEASE, 32'd5,          0, '0, 1'b0, '0},
        '{ROW_EVENT, KIND_QUERY,   32'hFFFF_FFFF,  0, '0, 1'b0, '0},
        '{ROW_WRITE, KIND_QUERY, '0, REG_PERCENT,  32'd0,         1'b0, '0},
        '{ROW_WRITE, KIND_QUERY, '0, NUM_REGS,     32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_WRITE, KIND_QUERY, '0, NUM_REGS + 2, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_WRITE, KIND_QUERY, '0, REG_BUDGET,   32'hFFF0_0064, 1'b0, '0},
        '{ROW_EVENT, KIND_ACQUIRE, 32'd6,          0, '0, 1'b0, '0},
        '{ROW_EVENT, KIND_QUERY,   32'd7,          0, '0, 1'b0, '0},
        '{ROW_WRITE, KIND_QUERY, '0, REG_QUIET,    32'hFFFF_0000, 1'b0, '0},
        '{ROW_EVENT, KIND_ACQUIRE, 32'd8,          0, '0, 1'b0, '0},
        '{ROW_EVENT, KIND_RELEASE, 32'd9,          0, '0, 1'b0, '0}
    };

    // Random phases: register settings, event mix and time step per event
    phase_plan_t plan [NUM_PHASES] = '{
        '{32'd1048575, 32'd127, 32'd0,     32'd0,     32'd0,     320, 96,  2,  1,     3},
        '{32'd5000,    32'd30,  32'd65535, 32'd65535, 32'd65535,  30, 40, 30, 20, 30000},
        '{32'd0,       32'd50,  32'd100,   32'd50,    32'd300,    40, 45, 25, 20,   150},
        '{32'd1,       32'd10,  32'd0,     32'd0,     32'd0,      25, 40, 30, 20,    10},
        '{32'd100000,  32'd64,  32'd3000,  32'd1000,  32'd500,    40, 50, 20, 20,   800}
    };

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", what);
    endtask

    function automatic logic [SLOT_W-1:0] eff_limit();
        return (lim_static < lim_dyn) ? lim_static : lim_dyn;
    endfunction

    // Static limit from budget and share, only while a budget is set
    function automatic void refresh_static();
        logic [31:0] quot;
        if (cfg_budget == '0)
            return;
        quot = 32'(cfg_budget) * 32'(cfg_pct) / PCT_SCALE / MB_PER_SLOT;
        if (quot < 32'(STATIC_MIN))
            quot = 32'(STATIC_MIN);
        if (quot > 32'(STATIC_MAX))
            quot = 32'(STATIC_MAX);
        lim_static = quot[SLOT_W-1:0];
    endfunction

    function automatic void apply_reg_write(int unsigned idx, logic [31:0] val);
        logic [PCT_W-1:0] share;
        case (idx)
            REG_BUDGET:
            begin
                cfg_budget = val[BUDGET_W-1:0];
                refresh_static();
            end
            REG_PERCENT:
            begin
                share = val[PCT_W-1:0];
                if (share < PCT_MIN)
                    share = PCT_MIN;
                if (share > PCT_MAX)
                    share = PCT_MAX;
                cfg_pct = share;
                refresh_static();
            end
            REG_QUIET: cfg_quiet     = val[IVL_W-1:0];
            REG_RAISE: cfg_raise_ivl = val[IVL_W-1:0];
            REG_DROP:  cfg_drop_ivl  = val[IVL_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] reg_value(int unsigned idx);
        case (idx)
            REG_BUDGET:  return 32'(cfg_budget);
            REG_PERCENT: return 32'(cfg_pct);
            REG_QUIET:   return 32'(cfg_quiet);
            REG_RAISE:   return 32'(cfg_raise_ivl);
            default:     return 32'(cfg_drop_ivl);
        endcase
    endfunction

    // Admission decision for one event; advances the model state
    function automatic verdict_t predict_admission(kind_t kind, logic [TIME_W-1:0] now);
        verdict_t          v;
        logic [SLOT_W-1:0] target;
        v = '0;
        case (kind)
            KIND_ACQUIRE:
            begin
                if (lim_dyn < lim_static && (now - t_fail) >= 32'(cfg_quiet)
                    && (now - t_raise) >= 32'(cfg_raise_ivl))
                begin
                    t_raise = now;
                    lim_dyn = lim_dyn + RAISE_STEP;
                end
                if (held < eff_limit())
                begin
                    held = held + 1'b1;
                    v.granted = 1'b1;
                end
            end
            KIND_RELEASE:
            begin
                if (held != '0)
                    held = held - 1'b1;
            end
            KIND_FAILURE:
            begin
                t_fail = now;
                if ((now - t_drop) >= 32'(cfg_drop_ivl))
                begin
                    t_drop = now;
                    target = (held > DROP_MARGIN) ? held - DROP_MARGIN : '0;
                    if (target < DROP_FLOOR)
                        target = DROP_FLOOR;
                    if (target < lim_dyn)
                        lim_dyn = target;
                end
            end
            default: ;
        endcase
        v.in_use = held;
        v.limit  = eff_limit();
        return v;
    endfunction

    // One input beat; sender idles first depending on the current mode
    task automatic send_event(kind_t kind, logic [31:0] now, bit known, verdict_t typed);
        verdict_t v;
        case ((events_sent / MODE_SPAN) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
        endcase
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= now;
        do
            @(posedge clk);
        while (!s_tready);
        v = predict_admission(kind, now);
        expected_verdicts.push_back(known ? typed : v);
        events_sent++;
    endtask

    // Quiesce the stream before touching registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(int unsigned idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * REG_STRIDE);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        apply_reg_write(idx, val);
        @(posedge clk);
    endtask

    task automatic readback_all();
        logic [31:0] got;
        for (int unsigned idx = 0; idx < NUM_REGS; idx++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= ADDR_W'(idx * REG_STRIDE);
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            got = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            if (got !== reg_value(idx))
                note_mismatch($sformatf("reg %0d read exp 0x%0h got 0x%0h",
                                        idx, reg_value(idx), got));
            @(posedge clk);
        end
    endtask

    // Result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        verdict_t want;
        verdict_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[0], m_tdata[9:1], m_tdata[18:10]};
            if (expected_verdicts.size() == 0)
                note_mismatch($sformatf("unexpected beat 0x%06h", m_tdata));
            else
            begin
                want = expected_verdicts.pop_front();
                if (got !== want || m_tdata[23:19] !== '0)
                    note_mismatch($sformatf(
                        "exp g=%0d use=%0d lim=%0d, got 0x%06h (g=%0d use=%0d lim=%0d)",
                        want.granted, want.in_use, want.limit, m_tdata,
                        got.granted, got.in_use, got.limit));
            end
        end
    end

    // Stimulus
    initial
    begin
        kind_t kind;
        int    pick;
        cfg_budget    = '0;
        cfg_pct       = PCT_RESET;
        cfg_quiet     = QUIET_RESET;
        cfg_raise_ivl = RAISE_RESET;
        cfg_drop_ivl  = DROP_RESET;
        held          = '0;
        lim_static    = STATIC_RESET;
        lim_dyn       = UNLIMITED;
        t_fail        = '0;
        t_raise       = '0;
        t_drop        = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        readback_all();

        for (int r = 0; r < SCRIPT_LEN; r++)
        begin
            if (script[r].op == ROW_WRITE)
            begin
                wait_idle();
                apb_write(script[r].reg_idx, script[r].wval);
            end
            else
                send_event(script[r].kind, script[r].now, script[r].known,
                           script[r].verdict);
        end
        wait_idle();
        readback_all();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            apb_write(REG_BUDGET,  plan[p].budget);
            apb_write(REG_PERCENT, plan[p].pct);
            apb_write(REG_QUIET,   plan[p].quiet);
            apb_write(REG_RAISE,   plan[p].raise);
            apb_write(REG_DROP,    plan[p].drop);
            readback_all();
            for (int n = 0; n < plan[p].n_events; n++)
            begin
                pick = $urandom_range(99);
                if (pick < plan[p].w_acq)
                    kind = KIND_ACQUIRE;
                else if (pick < plan[p].w_acq + plan[p].w_rel)
                    kind = KIND_RELEASE;
                else if (pick < plan[p].w_acq + plan[p].w_rel + plan[p].w_fail)
                    kind = KIND_FAILURE;
                else
                    kind = KIND_QUERY;
                // mostly advancing time, with an occasional jump anywhere
                if ($urandom_range(99) < 3)
                    clock_ms = $urandom();
                else
                    clock_ms = clock_ms + $urandom_range(plan[p].step_max, 0);
                send_event(kind, clock_ms, 1'b0, '0);
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/asa_pkg.sv
rtl/core/adaptive_slot_admission.sv
verif/tb_adaptive_slot_admission.sv
